### src/utf8dc_pkg.sv
package utf8dc_pkg;

    // field widths
    localparam int unsigned CP_W   = 21;
    localparam int unsigned FLAG_W = 8;
    localparam int unsigned POS_W  = 32;
    localparam int unsigned LEN_W  = 9;
    localparam int unsigned APB_AW = 3;
    localparam int unsigned APB_DW = 32;

    // register map
    localparam logic [APB_AW-1:0] ADDR_CLASS_LEN = 3'd0;

    // lexical word tag and byte codes
    localparam logic [63:0] LEX_TAG    = 64'hFFFC_4000_0000_0000;
    localparam logic [7:0]  NEWLINE    = 8'h0A;
    localparam logic [7:0]  LEAD2_MASK = 8'hE0;
    localparam logic [7:0]  LEAD2_VAL  = 8'hC0;
    localparam logic [7:0]  LEAD3_MASK = 8'hF0;
    localparam logic [7:0]  LEAD3_VAL  = 8'hE0;
    localparam logic [7:0]  LEAD4_MASK = 8'hF8;
    localparam logic [7:0]  LEAD4_VAL  = 8'hF0;

    typedef enum logic {
        KIND_BYTE  = 1'b0,
        KIND_ENTRY = 1'b1
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  source_byte;
        logic        final_byte;
        logic [7:0]  entry_index;
        logic [7:0]  entry_flags;
    } t_in_item;

    typedef struct packed {
        logic [CP_W-1:0]   code_point;
        logic [FLAG_W-1:0] class_flags;
        logic [63:0]       lexical_word;
        logic [POS_W-1:0]  start_offset;
        logic [POS_W-1:0]  start_line;
        logic              run_last;
    } t_out_item;

    // one decoded code point on its way to the table lookup
    typedef struct packed {
        logic [CP_W-1:0]  cp;
        logic [POS_W-1:0] off;
        logic [POS_W-1:0] line;
        logic             last;
    } t_result;

    // number of continuation bytes a lead byte takes
    function automatic logic [1:0] lead_need(input logic [7:0] b);
        logic [1:0] n;
        priority if ((b & LEAD2_MASK) == LEAD2_VAL) n = 2'd1;
        else if ((b & LEAD3_MASK) == LEAD3_VAL)      n = 2'd2;
        else if ((b & LEAD4_MASK) == LEAD4_VAL)      n = 2'd3;
        else                                         n = 2'd0;
        return n;
    endfunction

    function automatic logic [63:0] lex_word(input logic [CP_W-1:0] cp,
                                             input logic [FLAG_W-1:0] flags);
        return LEX_TAG | {25'b0, cp, 10'b0, flags};
    endfunction

endpackage

### src/utf8dc_in_if.sv
interface utf8dc_in_if;
    logic                 valid;
    logic                 ready;
    utf8dc_pkg::t_in_item item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

### src/utf8dc_out_if.sv
interface utf8dc_out_if;
    logic                  valid;
    logic                  ready;
    utf8dc_pkg::t_out_item item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

### src/utf8_decode_classify_top.sv
// Lenient UTF-8 decoder with per-code-point classification. One input transfer is
// taken every cycle while the lookup stage is free and no results wait for replay:
// kind 0 feeds a source byte, kind 1 writes one entry of the class flag table. A code
// point passes the lookup stage (synchronous table read), then the output register.
// A final byte that ends the source inside a sequence yields up to three results; the
// input is held while these are issued, since the class table has a single read port
// and does one lookup per cycle. The table needs no clearing pass: entries are
// undefined until written and must be loaded before they are looked up.
// class_table_length sits at APB byte address 0.
module utf8_decode_classify_top #(
    parameter int unsigned TABLE_SIZE = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    utf8dc_in_if.sink                     i_in,
    utf8dc_out_if.source                  o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [utf8dc_pkg::APB_AW-1:0] paddr,
    input  logic [utf8dc_pkg::APB_DW-1:0] pwdata,
    output logic [utf8dc_pkg::APB_DW-1:0] prdata,
    output logic                          pready
);

    localparam int unsigned DEPTH = (TABLE_SIZE < 256) ? TABLE_SIZE : 256;
    localparam int unsigned AW    = $clog2(DEPTH);

    // configuration register
    logic [utf8dc_pkg::LEN_W-1:0] r_class_len;

    // decoder state
    logic [7:0]                   r_pend [3];
    logic [1:0]                   r_pend_cnt;
    logic [utf8dc_pkg::POS_W-1:0] r_byte_pos;
    logic [utf8dc_pkg::POS_W-1:0] r_line;
    logic [utf8dc_pkg::POS_W-1:0] r_seq_off;
    logic [utf8dc_pkg::POS_W-1:0] r_seq_line;
    logic [7:0]                   n_pend [3];
    logic [1:0]                   n_pend_cnt;
    logic [utf8dc_pkg::POS_W-1:0] n_byte_pos;
    logic [utf8dc_pkg::POS_W-1:0] n_line;
    logic [utf8dc_pkg::POS_W-1:0] n_seq_off;
    logic [utf8dc_pkg::POS_W-1:0] n_seq_line;

    // replay of extra results at end of source
    utf8dc_pkg::t_result r_rep [2];
    logic [1:0]          r_rep_cnt;

    // lookup stage and output register
    logic                r_s1_valid;
    utf8dc_pkg::t_result r_s1;
    logic                r_s1_inr;
    logic [7:0]          r_tbl_q;
    logic [7:0]          r_table [DEPTH];
    logic                  r_out_valid;
    utf8dc_pkg::t_out_item r_out;

    // combinational decode
    logic [7:0]                   buf_b [4];
    logic [2:0]                   cnt;
    logic [1:0]                   need;
    logic                         complete;
    logic                         emit;
    logic [utf8dc_pkg::POS_W-1:0] sof;
    logic [utf8dc_pkg::POS_W-1:0] ln0;
    logic [utf8dc_pkg::POS_W-1:0] ln1;
    logic [utf8dc_pkg::POS_W-1:0] ln2;
    utf8dc_pkg::t_result          res [3];
    logic [1:0]                   res_k;

    // handshake and issue
    logic                s1_adv;
    logic                s1_free;
    logic                acc;
    logic                acc_byte;
    logic                acc_entry;
    logic                issue_new;
    logic                issue_rep;
    logic                s1_load;
    utf8dc_pkg::t_result issue_res;
    logic                issue_inr;

    // apb register port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_class_len <= '0;
        end else if (psel && penable && pwrite && paddr == utf8dc_pkg::ADDR_CLASS_LEN) begin
            r_class_len <= pwdata[utf8dc_pkg::LEN_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == utf8dc_pkg::ADDR_CLASS_LEN)
                  ? {{(utf8dc_pkg::APB_DW - utf8dc_pkg::LEN_W){1'b0}}, r_class_len}
                  : '0;

    // handshake
    assign s1_adv       = r_s1_valid && (!r_out_valid || o_out.ready);
    assign s1_free      = !r_s1_valid || s1_adv;
    assign i_in.ready   = s1_free && (r_rep_cnt == 2'd0);
    assign acc          = i_in.valid && i_in.ready;
    assign acc_byte     = acc && (i_in.item.kind == utf8dc_pkg::KIND_BYTE);
    assign acc_entry    = acc && (i_in.item.kind == utf8dc_pkg::KIND_ENTRY);

    // gather pending bytes and the new byte
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (i < int'(r_pend_cnt)) begin
                buf_b[i] = r_pend[i];
            end else if (i == int'(r_pend_cnt)) begin
                buf_b[i] = i_in.item.source_byte;
            end else begin
                buf_b[i] = 8'h00;
            end
        end
        buf_b[3] = (r_pend_cnt == 2'd3) ? i_in.item.source_byte : 8'h00;
    end

    assign cnt      = {1'b0, r_pend_cnt} + 3'd1;
    assign need     = utf8dc_pkg::lead_need(buf_b[0]);
    assign complete = ({1'b0, need} < cnt);
    assign emit     = complete || i_in.item.final_byte;
    assign sof      = (r_pend_cnt == 2'd0) ? r_byte_pos : r_seq_off;
    assign ln0      = (r_pend_cnt == 2'd0) ? r_line : r_seq_line;
    assign ln1      = ln0 + utf8dc_pkg::POS_W'(buf_b[0] == utf8dc_pkg::NEWLINE);
    assign ln2      = ln1 + utf8dc_pkg::POS_W'(buf_b[1] == utf8dc_pkg::NEWLINE);

    // results of this byte: one sequence, or the raw lead and its tail, redecoded where it forms a two-byte sequence
    always_comb begin
        res[0]      = '{cp: {13'b0, buf_b[0]}, off: sof, line: ln0, last: 1'b0};
        res[1]      = '{cp: {13'b0, buf_b[1]}, off: sof + 32'd1, line: ln1, last: 1'b0};
        res[2]      = '{cp: {13'b0, buf_b[2]}, off: sof + 32'd2, line: ln2, last: 1'b0};
        res_k       = 2'd1;
        if (complete) begin
            unique case (need)
                2'd0: res[0].cp = {13'b0, buf_b[0]};
                2'd1: res[0].cp = {10'b0, buf_b[0][4:0], buf_b[1][5:0]};
                2'd2: res[0].cp = {5'b0, buf_b[0][3:0], buf_b[1][5:0], buf_b[2][5:0]};
                2'd3: res[0].cp = {buf_b[0][2:0], buf_b[1][5:0], buf_b[2][5:0],
                                   buf_b[3][5:0]};
                default: res[0].cp = {13'b0, buf_b[0]};
            endcase
        end else if (cnt == 3'd2) begin
            res_k = 2'd2;
        end else if (cnt == 3'd3) begin
            if (utf8dc_pkg::lead_need(buf_b[1]) == 2'd1) begin
                res[1].cp = {10'b0, buf_b[1][4:0], buf_b[2][5:0]};
                res_k     = 2'd2;
            end else begin
                res_k     = 2'd3;
            end
        end
        for (int i = 0; i < 3; i++) begin
            res[i].last = (i == int'(res_k) - 1);
        end
    end

    // decoder state next values
    always_comb begin
        n_pend     = r_pend;
        n_pend_cnt = r_pend_cnt;
        n_byte_pos = r_byte_pos;
        n_line     = r_line;
        n_seq_off  = r_seq_off;
        n_seq_line = r_seq_line;
        if (acc_byte) begin
            if (r_pend_cnt == 2'd0) begin
                n_seq_off  = r_byte_pos;
                n_seq_line = r_line;
            end
            if (!emit) begin
                for (int i = 0; i < 3; i++) begin
                    if (i == int'(r_pend_cnt)) begin
                        n_pend[i] = i_in.item.source_byte;
                    end
                end
                n_pend_cnt = r_pend_cnt + 2'd1;
            end else begin
                n_pend_cnt = 2'd0;
            end
            n_line     = r_line
                       + utf8dc_pkg::POS_W'(i_in.item.source_byte == utf8dc_pkg::NEWLINE);
            n_byte_pos = r_byte_pos + 32'd1;
            if (i_in.item.final_byte) begin
                n_byte_pos = '0;
                n_line     = 32'd1;
                n_pend_cnt = 2'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_cnt <= 2'd0;
            r_byte_pos <= '0;
            r_line     <= 32'd1;
            r_seq_off  <= '0;
            r_seq_line <= 32'd1;
        end else begin
            r_pend_cnt <= n_pend_cnt;
            r_byte_pos <= n_byte_pos;
            r_line     <= n_line;
            r_seq_off  <= n_seq_off;
            r_seq_line <= n_seq_line;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
    end

    // issue one code point per cycle into the lookup stage while it is free
    assign issue_new = acc_byte && emit;
    assign issue_rep = s1_free && (r_rep_cnt != 2'd0);
    assign s1_load   = issue_new || issue_rep;
    assign issue_res = issue_rep ? r_rep[0] : res[0];
    assign issue_inr = (32'(issue_res.cp) < DEPTH)
                    && (issue_res.cp < {12'b0, r_class_len});

    // replay queue control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rep_cnt <= 2'd0;
        end else if (issue_new) begin
            r_rep_cnt <= res_k - 2'd1;
        end else if (issue_rep) begin
            r_rep_cnt <= r_rep_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue_new) begin
            r_rep[0] <= res[1];
            r_rep[1] <= res[2];
        end else if (issue_rep) begin
            r_rep[0] <= r_rep[1];
        end
    end

    // class table: write on entry transfer, registered read on issue
    always_ff @(posedge i_clk) begin
        if (acc_entry && (32'(i_in.item.entry_index) < DEPTH)) begin
            r_table[i_in.item.entry_index[AW-1:0]] <= i_in.item.entry_flags;
        end
        if (s1_load) begin
            r_tbl_q <= r_table[issue_res.cp[AW-1:0]];
        end
    end

    // lookup stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_load) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_load) begin
            r_s1     <= issue_res;
            r_s1_inr <= issue_inr;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out.code_point   <= r_s1.cp;
            r_out.class_flags  <= r_s1_inr ? r_tbl_q : 8'h00;
            r_out.lexical_word <= utf8dc_pkg::lex_word(r_s1.cp, r_s1_inr ? r_tbl_q : 8'h00);
            r_out.start_offset <= r_s1.off;
            r_out.start_line   <= r_s1.line;
            r_out.run_last     <= r_s1.last;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.item  = r_out;

    // a pending sequence is always shorter than its lead byte asks for
    a_pend_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_cnt != 2'd0 |-> utf8dc_pkg::lead_need(r_pend[0]) >= r_pend_cnt)
        else $error("pending bytes exceed what the lead byte takes");

    // a final byte restarts offset, line and pending sequence
    a_final_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_byte && i_in.item.final_byte |=>
            r_byte_pos == '0 && r_line == 32'd1 && r_pend_cnt == 2'd0)
        else $error("counters not restarted after final byte");

    // replayed results always sit behind a loaded lookup stage
    a_rep_behind_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rep_cnt != 2'd0 |-> r_s1_valid && !r_s1.last)
        else $error("replay queue not behind lookup stage");

    // no new byte is taken while replay results remain
    a_rep_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        issue_new |=> r_rep_cnt == 2'd0 || !acc)
        else $error("input transfer taken during replay");

endmodule

### bench/utf8dc_stream_checker.sv
module utf8dc_stream_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    utf8dc_in_if                          i_in_ch,
    utf8dc_out_if                         i_out_ch,
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [utf8dc_pkg::APB_AW-1:0] i_paddr,
    input  logic [utf8dc_pkg::APB_DW-1:0] i_pwdata,
    input  logic                          i_pready,
    output int                            o_fail_count,
    output int                            o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // decoder state as the block should hold it
    logic [utf8dc_pkg::FLAG_W-1:0] flag_table [256];
    logic [utf8dc_pkg::LEN_W-1:0]  table_len;
    logic [7:0]                    held_bytes [3];
    int unsigned                   held_cnt;
    logic [utf8dc_pkg::POS_W-1:0]  byte_pos;
    logic [utf8dc_pkg::POS_W-1:0]  line_no;
    logic [utf8dc_pkg::POS_W-1:0]  seq_off;
    logic [utf8dc_pkg::POS_W-1:0]  seq_line;

    utf8dc_pkg::t_out_item         expected_q [$];
    utf8dc_pkg::t_out_item         exp_item;
    int                            mismatches;

    // continuation bytes that a lead byte takes
    function automatic int unsigned cont_count(logic [7:0] b);
        casez (b)
            8'b110?????: return 1;
            8'b1110????: return 2;
            8'b11110???: return 3;
            default:     return 0;
        endcase
    endfunction

    function automatic logic [utf8dc_pkg::FLAG_W-1:0] flags_of(
        logic [utf8dc_pkg::CP_W-1:0] cp);
        if (cp < table_len && cp < 256) begin
            return flag_table[cp[7:0]];
        end
        return '0;
    endfunction

    function automatic int field_diff(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t %s: expected %0h, actual %0h", $time, name, exp_v, act_v);
            return 1;
        end
        return 0;
    endfunction

    // one accepted input transfer: update state, queue the code points it completes
    task automatic predict_item(utf8dc_pkg::t_in_item it);
        logic [7:0]                   run [4];
        logic [utf8dc_pkg::POS_W-1:0] run_line [4];
        logic [utf8dc_pkg::POS_W-1:0] ln;
        logic [utf8dc_pkg::CP_W-1:0]  cp;
        int unsigned                  cnt;
        int unsigned                  i;
        int unsigned                  n;
        int unsigned                  first;
        utf8dc_pkg::t_out_item        r;
        if (it.kind == utf8dc_pkg::KIND_ENTRY) begin
            flag_table[it.entry_index] = it.entry_flags;
            return;
        end
        if (held_cnt == 0) begin
            seq_off  = byte_pos;
            seq_line = line_no;
        end
        for (i = 0; i < held_cnt; i++) run[i] = held_bytes[i];
        run[held_cnt] = it.source_byte;
        cnt = held_cnt + 1;

        if (cont_count(run[0]) + 1 > cnt && !it.final_byte) begin
            // sequence still open
            for (i = 0; i < cnt; i++) held_bytes[i] = run[i];
            held_cnt = cnt;
        end else begin
            // decode the whole run, a short tail at end of source comes out raw
            ln = seq_line;
            for (i = 0; i < cnt; i++) begin
                run_line[i] = ln;
                if (run[i] == utf8dc_pkg::NEWLINE) ln++;
            end
            i = 0;
            while (i < cnt) begin
                first = i;
                n = cont_count(run[i]);
                if (n > 0 && i + n < cnt) begin
                    case (n)
                        1:       cp = utf8dc_pkg::CP_W'(run[i][4:0]);
                        2:       cp = utf8dc_pkg::CP_W'(run[i][3:0]);
                        default: cp = utf8dc_pkg::CP_W'(run[i][2:0]);
                    endcase
                    for (int j = 1; j <= n; j++) begin
                        cp = {cp[utf8dc_pkg::CP_W-7:0], run[i+j][5:0]};
                    end
                    i += n + 1;
                end else begin
                    cp = utf8dc_pkg::CP_W'(run[i]);
                    i++;
                end
                r.code_point   = cp;
                r.class_flags  = flags_of(cp);
                r.lexical_word = utf8dc_pkg::LEX_TAG | (64'(cp) << 18)
                               | 64'(r.class_flags);
                r.start_offset = seq_off + first;
                r.start_line   = run_line[first];
                r.run_last     = (i >= cnt);
                expected_q.push_back(r);
            end
            held_cnt = 0;
        end

        if (it.source_byte == utf8dc_pkg::NEWLINE) line_no++;
        byte_pos++;
        if (it.final_byte) begin
            byte_pos = '0;
            line_no  = 1;
            held_cnt = 0;
        end
    endtask

    // watch config, input and output transfers
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            table_len  = '0;
            held_cnt   = 0;
            byte_pos   = '0;
            line_no    = 1;
            seq_off    = '0;
            seq_line   = 1;
            mismatches = 0;
            expected_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready
                && i_paddr == utf8dc_pkg::ADDR_CLASS_LEN) begin
                table_len = i_pwdata[utf8dc_pkg::LEN_W-1:0];
            end
            if (i_in_ch.valid && i_in_ch.ready) begin
                predict_item(i_in_ch.item);
            end
            if (i_out_ch.valid && i_out_ch.ready) begin
                if (expected_q.size() == 0) begin
                    $display("%0t unexpected result: expected none, actual cp %0h", $time,
                             i_out_ch.item.code_point);
                    mismatches++;
                end else begin
                    exp_item = expected_q.pop_front();
                    mismatches += field_diff("code_point", 64'(exp_item.code_point),
                                             64'(i_out_ch.item.code_point));
                    mismatches += field_diff("class_flags", 64'(exp_item.class_flags),
                                             64'(i_out_ch.item.class_flags));
                    mismatches += field_diff("lexical_word", exp_item.lexical_word,
                                             i_out_ch.item.lexical_word);
                    mismatches += field_diff("start_offset", 64'(exp_item.start_offset),
                                             64'(i_out_ch.item.start_offset));
                    mismatches += field_diff("start_line", 64'(exp_item.start_line),
                                             64'(i_out_ch.item.start_line));
                    mismatches += field_diff("run_last", 64'(exp_item.run_last),
                                             64'(i_out_ch.item.run_last));
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_q.size();
    end

endmodule

### bench/tb_utf8_decode_classify_top.sv
module tb_utf8_decode_classify_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          psel;
    logic                          penable;
    logic                          pwrite;
    logic [utf8dc_pkg::APB_AW-1:0] paddr;
    logic [utf8dc_pkg::APB_DW-1:0] pwdata;
    logic [utf8dc_pkg::APB_DW-1:0] prdata;
    logic                          pready;
    int                            fail_count;
    int                            pending;
    int                            idle_cycles = 0;
    bit                            calm;

    utf8dc_in_if  in_ch ();
    utf8dc_out_if out_ch ();

    utf8_decode_classify_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    utf8dc_stream_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_ch      (in_ch),
        .i_out_ch     (out_ch),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // stretches with and without idling on both sides
    initial begin
        calm <= 1'b0;
        forever begin
            repeat ($urandom_range(20, 80)) @(posedge i_clk);
            calm <= ($urandom_range(0, 2) == 0);
        end
    end

    // result side: random stall before each transfer
    initial begin
        int stall;
        out_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_ch.valid) @(posedge i_clk);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic write_class_len(logic [utf8dc_pkg::LEN_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= utf8dc_pkg::ADDR_CLASS_LEN;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_item(utf8dc_pkg::t_in_item it);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.item  <= it;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic send_byte(logic [7:0] b, logic fin);
        utf8dc_pkg::t_in_item it;
        it.kind        = utf8dc_pkg::KIND_BYTE;
        it.source_byte = b;
        it.final_byte  = fin;
        it.entry_index = 8'($urandom);
        it.entry_flags = 8'($urandom);
        send_item(it);
    endtask

    task automatic send_entry(logic [7:0] idx, logic [7:0] flags);
        utf8dc_pkg::t_in_item it;
        it.kind        = utf8dc_pkg::KIND_ENTRY;
        it.source_byte = 8'($urandom);
        it.final_byte  = 1'($urandom);
        it.entry_index = idx;
        it.entry_flags = flags;
        send_item(it);
    endtask

    // well-formed character with random content, sometimes cut by end of source
    task automatic send_char();
        int unsigned len;
        logic [7:0]  lead;
        case ($urandom_range(0, 5))
            0, 1, 2: len = 1;
            3:       len = 2;
            4:       len = 3;
            default: len = 4;
        endcase
        case (len)
            1: lead = 8'($urandom_range(0, 127));
            2: lead = {3'b110, ($urandom_range(0, 1) ? 5'($urandom_range(0, 3)) : 5'($urandom))};
            3: lead = {4'b1110, 4'($urandom)};
            default: lead = {5'b11110, 3'($urandom)};
        endcase
        send_byte(lead, $urandom_range(0, 11) == 0);
        for (int j = 1; j < len; j++) begin
            send_byte({2'b10, 6'($urandom)}, $urandom_range(0, 11) == 0);
        end
    endtask

    // wait until the result side has drained and the pipeline is quiet
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic run_phase(logic [utf8dc_pkg::LEN_W-1:0] len, int steps);
        write_class_len(len);
        for (int k = 0; k < steps; k++) begin
            case ($urandom_range(0, 9))
                0: send_byte(8'($urandom), $urandom_range(0, 5) == 0);
                // lone lead byte, whatever follows gets swallowed
                1: send_byte({3'b111, 5'($urandom)} & 8'hF7, 1'b0);
                2: send_entry(8'($urandom), 8'($urandom));
                3: send_byte(utf8dc_pkg::NEWLINE, 1'b0);
                default: send_char();
            endcase
        end
        send_byte(8'($urandom_range(0, 127)), 1'b1);
        settle();
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.item  <= '0;
        psel        <= 1'b0;
        penable     <= 1'b0;
        pwrite      <= 1'b0;
        paddr       <= '0;
        pwdata      <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_class_len('0);

        // directed: plain bytes, each sequence length, lenient and cut sequences
        send_byte(8'h41, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(utf8dc_pkg::NEWLINE, 1'b0);
        send_byte(8'hC3, 1'b0);
        send_byte(8'hA9, 1'b0);
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b0);
        send_byte(8'hAC, 1'b0);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h9F, 1'b0);
        send_byte(8'h98, 1'b0);
        send_byte(8'h80, 1'b0);
        // newline swallowed as continuation still counts a line
        send_byte(8'hC2, 1'b0);
        send_byte(utf8dc_pkg::NEWLINE, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b0);
        // table write in the middle of a sequence leaves it open
        send_byte(8'hE1, 1'b0);
        send_entry(8'hFF, 8'hFF);
        send_byte(8'h80, 1'b0);
        send_byte(8'hBF, 1'b0);
        // source ends inside a sequence: three raw results
        send_byte(8'hF4, 1'b0);
        send_byte(utf8dc_pkg::NEWLINE, 1'b0);
        send_byte(8'hC3, 1'b1);
        // cut sequence whose tail decodes as a shorter one
        send_byte(8'hF0, 1'b0);
        send_byte(8'hC3, 1'b0);
        send_byte(8'hA9, 1'b1);
        send_byte(8'hF7, 1'b1);

        // load the low table entries; every random phase length stays within them
        for (int idx = 0; idx < 64; idx++) send_entry(8'(idx), 8'($urandom));
        settle();

        // length beyond the table: low code points and ones past the table end
        write_class_len(9'd511);
        send_byte(8'h21, 1'b0);
        send_byte(8'hC5, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hF4, 1'b0);
        send_byte(8'h8F, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b1);
        settle();

        run_phase(9'd64, 11);
        run_phase(9'd1, 11);
        run_phase(9'($urandom_range(2, 63)), 11);

        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
